### rtl/fmbs_pkg.sv
// shared constants, codes and symbol counting for the fm-index backward search
package fmbs_pkg;

   localparam int CNT_W              = 21;
   localparam int DATA_W             = 32;
   localparam int ADDR_W             = 16;
   localparam int SYM_W              = 3;
   localparam int CSR_IDX_W          = 3;
   localparam int WORD_AW            = 16;
   localparam int WORD_DEPTH         = 65536;
   localparam int CKPT_AW            = 16;
   localparam int CKPT_DEPTH         = 32772;
   localparam int INTERVAL_SHIFT_DEF = 7;

   // request kinds
   localparam logic [1:0] KIND_BWT  = 2'd0;
   localparam logic [1:0] KIND_CKPT = 2'd1;
   localparam logic [1:0] KIND_SYM  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_LEN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIMARY  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUM_C    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CUM_G    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CUM_T    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CUM_ALL  = 3'd5;

   // number of two-bit symbols equal to c in a packed word
   function automatic logic [4:0] count_sym(input logic [31:0] y_in, input logic [1:0] c);
      logic [31:0] hi;
      logic [31:0] lo;
      logic [31:0] y;
      hi = c[1] ? 32'h0 : 32'hFFFF_FFFF;
      lo = c[0] ? 32'h0 : 32'hFFFF_FFFF;
      y  = ((y_in ^ hi) >> 1) & (y_in ^ lo) & 32'h5555_5555;
      y  = (y & 32'h3333_3333) + ((y >> 2) & 32'h3333_3333);
      y  = (y + (y >> 4)) & 32'h0F0F_0F0F;
      return y[4:0] + y[12:8] + y[20:16] + y[28:24];
   endfunction

endpackage

### rtl/fmbs_ifs.sv
// request, response and register write channels
interface fmbs_req_if;
   import fmbs_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          kind;
   logic [ADDR_W-1:0]   addr;
   logic [DATA_W-1:0]   data;
   logic [SYM_W-1:0]    sym;
   logic                first;
   logic                last;
   modport source (output valid, kind, addr, data, sym, first, last, input ready);
   modport sink   (input valid, kind, addr, data, sym, first, last, output ready);
endinterface

interface fmbs_rsp_if;
   import fmbs_pkg::*;
   logic                valid;
   logic                ready;
   logic                found;
   logic [CNT_W-1:0]    hit_count;
   logic [CNT_W-1:0]    sa_begin;
   logic [CNT_W-1:0]    sa_end;
   modport source (output valid, found, hit_count, sa_begin, sa_end, input ready);
   modport sink   (input valid, found, hit_count, sa_begin, sa_end, output ready);
endinterface

interface fmbs_csr_if;
   import fmbs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/fm_index_backward_search_top.sv
// fm-index backward search: memories, bound sequencer and result register
// a load request is taken in S_IDLE; a pattern symbol passes S_SETUP, then S_OCC reads
// nl and nr words for the bounds counted from memory (nl, nr: words from the interval start
// to the bound, 1 to 2^(shift-4)), one word read per cycle, then S_UPD and S_FIN; a skipped
// symbol goes from S_IDLE to S_FIN. a result leaves S_FIN via S_OUT into the result register
// reset (synchronous, high) clears range, failure flag and registers; memories are not cleared
module fm_index_backward_search_top
   import fmbs_pkg::*;
#(
   parameter int INTERVAL_SHIFT = INTERVAL_SHIFT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   fmbs_req_if.sink   req_bus,
   fmbs_rsp_if.source rsp_bus,
   fmbs_csr_if.sink   csr_bus
);

   localparam int JW = INTERVAL_SHIFT - 3;
   localparam logic [CNT_W-1:0] WSUB_MASK = (CNT_W'(1) << (INTERVAL_SHIFT - 4)) - CNT_W'(1);

   typedef enum logic [2:0] {S_IDLE, S_SETUP, S_OCC, S_UPD, S_FIN, S_OUT} state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] tlen_ff, prim_ff, cum_c_ff, cum_g_ff, cum_t_ff, cum_all_ff;
   logic [CNT_W-1:0] low_ff, low_in, high_ff, high_in;
   logic             fail_ff, fail_in;
   logic [1:0]       c_ff, c_in;
   logic             last_ff, last_in;
   logic [CNT_W-1:0] kl_ff, kl_in, kr_ff, kr_in;
   logic             needl_in, needr_ff, needr_in;
   logic [CNT_W-1:0] ol_ff, ol_in, or_ff, or_in;
   logic             sel_ff, sel_in;
   logic [JW-1:0]    j_ff, j_in;
   logic             idone_ff, idone_in;
   logic             pend_ff, pend_in, pfirst_ff, pfirst_in, plast_ff, plast_in;
   logic             ckok_ff, ckok_in;
   logic [CNT_W-1:0] acc_ff, acc_in;
   logic             rvalid_ff, rvalid_in, rfound_ff, rfound_in;
   logic [CNT_W-1:0] rhit_ff, rhit_in, rbeg_ff, rbeg_in, rend_ff, rend_in;

   // memory ports
   logic               bwt_we;
   logic [WORD_AW-1:0] bwt_raddr;
   logic [DATA_W-1:0]  bwt_rdata;
   logic               ck_we;
   logic [CKPT_AW-1:0] ck_waddr, ck_raddr;
   logic [CNT_W-1:0]   ck_rdata;

   fmbs_ram #(.WIDTH(DATA_W), .DEPTH(WORD_DEPTH), .AW(WORD_AW)) u_bwt (
      .clock (clock),
      .we    (bwt_we),
      .waddr (req_bus.addr),
      .wdata (req_bus.data),
      .raddr (bwt_raddr),
      .rdata (bwt_rdata)
   );

   fmbs_ram #(.WIDTH(CNT_W), .DEPTH(CKPT_DEPTH), .AW(CKPT_AW)) u_ckpt (
      .clock (clock),
      .we    (ck_we),
      .waddr (ck_waddr),
      .wdata (req_bus.data[CNT_W-1:0]),
      .raddr (ck_raddr),
      .rdata (ck_rdata)
   );

   function automatic logic [CNT_W-1:0] cum_sel(input logic [2:0] s,
         input logic [CNT_W-1:0] cc, input logic [CNT_W-1:0] cg,
         input logic [CNT_W-1:0] ct, input logic [CNT_W-1:0] ca);
      logic [CNT_W-1:0] v;
      case (s)
         3'd1:    v = cc;
         3'd2:    v = cg;
         3'd3:    v = ct;
         3'd4:    v = ca;
         default: v = '0;
      endcase
      return v;
   endfunction

   logic             req_acc;
   logic [17:0]      ck_widx;
   logic             lm1, same;
   logic [CNT_W-1:0] lpos, la, ra, base, cumdiff;
   logic [CNT_W-1:0] kcur, ck_ridx, wmask_k;
   logic [JW-1:0]    jlast;
   logic [3:0]       drop;
   logic [31:0]      wmask, wsel;
   logic [4:0]       wcnt;
   logic [CNT_W-1:0] acc_sum, occ_val;
   logic             new_first_fail;

   assign req_acc       = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;

   // load writes
   assign ck_widx  = {req_bus.addr, 2'b00} | 18'(req_bus.sym[1:0]);
   assign bwt_we   = req_acc && (req_bus.kind == KIND_BWT);
   assign ck_we    = req_acc && (req_bus.kind == KIND_CKPT) && !req_bus.sym[2]
                     && (ck_widx < 18'(CKPT_DEPTH));
   assign ck_waddr = CKPT_AW'(ck_widx);

   // bound positions after the primary-row shift
   assign lm1     = (low_ff == '0);
   assign lpos    = low_ff - CNT_W'(1);
   assign la      = (!lm1 && lpos >= prim_ff) ? lpos - CNT_W'(1) : lpos;
   assign ra      = (high_ff >= prim_ff) ? high_ff - CNT_W'(1) : high_ff;
   assign same    = !lm1 && ((la >> INTERVAL_SHIFT) == (ra >> INTERVAL_SHIFT));
   assign base    = cum_sel({1'b0, c_ff}, cum_c_ff, cum_g_ff, cum_t_ff, cum_all_ff);
   assign cumdiff = cum_sel(3'({1'b0, c_ff}) + 3'd1, cum_c_ff, cum_g_ff, cum_t_ff, cum_all_ff)
                    - base;

   // occ walk over the words of one interval
   assign kcur      = sel_ff ? kr_ff : kl_ff;
   assign jlast     = JW'((kcur >> 4) & WSUB_MASK);
   assign wmask_k   = ((kcur >> 4) & ~WSUB_MASK) | CNT_W'(j_ff);
   assign bwt_raddr = WORD_AW'(wmask_k);
   assign ck_ridx   = ((kcur >> INTERVAL_SHIFT) << 2) | CNT_W'(c_ff);
   assign ck_raddr  = CKPT_AW'(ck_ridx);
   assign drop      = ~kcur[3:0];
   assign wmask     = ~((32'd1 << {drop, 1'b0}) - 32'd1);
   assign wsel      = plast_ff ? (bwt_rdata & wmask) : bwt_rdata;
   assign wcnt      = count_sym(wsel, c_ff);
   assign acc_sum   = acc_ff + CNT_W'(wcnt) + ((pfirst_ff && ckok_ff) ? ck_rdata : '0);
   assign occ_val   = acc_sum - ((c_ff == 2'd0) ? CNT_W'(drop) : '0);

   assign new_first_fail = req_bus.first ? 1'b0 : fail_ff;

   // next state and datapath
   always_comb begin
      state_in  = state_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      fail_in   = fail_ff;
      c_in      = c_ff;
      last_in   = last_ff;
      kl_in     = kl_ff;
      kr_in     = kr_ff;
      needl_in  = 1'b0;
      needr_in  = needr_ff;
      ol_in     = ol_ff;
      or_in     = or_ff;
      sel_in    = sel_ff;
      j_in      = j_ff;
      idone_in  = idone_ff;
      pend_in   = 1'b0;
      pfirst_in = 1'b0;
      plast_in  = 1'b0;
      ckok_in   = ckok_ff;
      acc_in    = acc_ff;
      rvalid_in = rvalid_ff && !rsp_bus.ready;
      rfound_in = rfound_ff;
      rhit_in   = rhit_ff;
      rbeg_in   = rbeg_ff;
      rend_in   = rend_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc && req_bus.kind == KIND_SYM) begin
               c_in    = req_bus.sym[1:0];
               last_in = req_bus.last;
               if (req_bus.first) begin
                  low_in  = '0;
                  high_in = tlen_ff;
               end
               fail_in  = new_first_fail || (!new_first_fail && req_bus.sym > 3'd3);
               state_in = fail_in ? S_FIN : S_SETUP;
            end
         end
         S_SETUP: begin
            kl_in    = la;
            kr_in    = ra;
            needl_in = same || (!lm1 && lpos != tlen_ff);
            needr_in = same || (high_ff != tlen_ff);
            ol_in    = lm1 ? '0 : cumdiff;
            or_in    = cumdiff;
            sel_in   = !needl_in;
            j_in     = '0;
            idone_in = 1'b0;
            acc_in   = '0;
            state_in = (needl_in || needr_in) ? S_OCC : S_UPD;
         end
         S_OCC: begin
            // issue one word read per cycle
            if (!idone_ff) begin
               pend_in   = 1'b1;
               pfirst_in = (j_ff == '0);
               plast_in  = (j_ff == jlast);
               idone_in  = (j_ff == jlast);
               j_in      = j_ff + JW'(1);
               if (j_ff == '0) begin
                  ckok_in = (ck_ridx < CNT_W'(CKPT_DEPTH));
               end
            end
            // accumulate returned words
            if (pend_ff) begin
               acc_in = acc_sum;
               if (plast_ff) begin
                  if (sel_ff) begin
                     or_in = occ_val;
                  end else begin
                     ol_in = occ_val;
                  end
                  if (!sel_ff && needr_ff) begin
                     sel_in   = 1'b1;
                     j_in     = '0;
                     idone_in = 1'b0;
                     acc_in   = '0;
                  end else begin
                     state_in = S_UPD;
                  end
               end
            end
         end
         S_UPD: begin
            low_in   = base + ol_ff + CNT_W'(1);
            high_in  = base + or_ff;
            fail_in  = fail_ff || (low_in > high_in);
            state_in = S_FIN;
         end
         S_FIN: begin
            state_in = last_ff ? S_OUT : S_IDLE;
         end
         S_OUT: begin
            if (!rvalid_ff || rsp_bus.ready) begin
               rvalid_in = 1'b1;
               rfound_in = !fail_ff;
               rhit_in   = fail_ff ? '0 : high_ff - low_ff + CNT_W'(1);
               rbeg_in   = fail_ff ? '0 : low_ff;
               rend_in   = fail_ff ? '0 : high_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         low_ff     <= '0;
         high_ff    <= '0;
         fail_ff    <= 1'b0;
         pend_ff    <= 1'b0;
         idone_ff   <= 1'b0;
         rvalid_ff  <= 1'b0;
         tlen_ff    <= '0;
         prim_ff    <= '0;
         cum_c_ff   <= '0;
         cum_g_ff   <= '0;
         cum_t_ff   <= '0;
         cum_all_ff <= '0;
      end else begin
         state_ff  <= state_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
         fail_ff   <= fail_in;
         pend_ff   <= pend_in;
         idone_ff  <= idone_in;
         rvalid_ff <= rvalid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_TEXT_LEN: tlen_ff    <= csr_bus.data[CNT_W-1:0];
               CSR_PRIMARY:  prim_ff    <= csr_bus.data[CNT_W-1:0];
               CSR_CUM_C:    cum_c_ff   <= csr_bus.data[CNT_W-1:0];
               CSR_CUM_G:    cum_g_ff   <= csr_bus.data[CNT_W-1:0];
               CSR_CUM_T:    cum_t_ff   <= csr_bus.data[CNT_W-1:0];
               CSR_CUM_ALL:  cum_all_ff <= csr_bus.data[CNT_W-1:0];
               default:      ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      c_ff      <= c_in;
      last_ff   <= last_in;
      kl_ff     <= kl_in;
      kr_ff     <= kr_in;
      needr_ff  <= needr_in;
      ol_ff     <= ol_in;
      or_ff     <= or_in;
      sel_ff    <= sel_in;
      j_ff      <= j_in;
      pfirst_ff <= pfirst_in;
      plast_ff  <= plast_in;
      ckok_ff   <= ckok_in;
      acc_ff    <= acc_in;
      rfound_ff <= rfound_in;
      rhit_ff   <= rhit_in;
      rbeg_ff   <= rbeg_in;
      rend_ff   <= rend_in;
   end

   assign rsp_bus.valid     = rvalid_ff;
   assign rsp_bus.found     = rfound_ff;
   assign rsp_bus.hit_count = rhit_ff;
   assign rsp_bus.sa_begin  = rbeg_ff;
   assign rsp_bus.sa_end    = rend_ff;

   // a failed search reports an empty range
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && !rfound_ff |-> rhit_ff == '0 && rbeg_ff == '0 && rend_ff == '0)
      else $error("failed search reports nonzero range");

   // failure stays set until a request starts a new pattern
   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      fail_ff && !(req_acc && req_bus.first) |=> fail_ff)
      else $error("failure flag cleared without a new pattern");

   // word walk never issues past the bound's word
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OCC && !idone_ff |-> j_ff <= jlast)
      else $error("word walk ran past the bound");

   // a pending result is only replaced after it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && !rsp_bus.ready |=> rvalid_ff && $stable(rhit_ff) && $stable(rbeg_ff))
      else $error("response changed while stalled");

endmodule

### rtl/fmbs_ram.sv
// generic simple dual-port ram with registered read
module fmbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
